/* src/macd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MACD package
// Shared types, register indexes and constants for the MACD indicator stream.
// ----------------------------------------------------------------------------
package macd_pkg;

  localparam int WEIGHT_WIDTH = 17;
  localparam int FRAC_BITS    = 16;

  localparam logic [WEIGHT_WIDTH-1:0] FAST_WEIGHT_RESET   = 17'd10082;
  localparam logic [WEIGHT_WIDTH-1:0] SLOW_WEIGHT_RESET   = 17'd4855;
  localparam logic [WEIGHT_WIDTH-1:0] SIGNAL_WEIGHT_RESET = 17'd13107;

  localparam logic [1:0] REG_FAST_WEIGHT   = 2'd0;
  localparam logic [1:0] REG_SLOW_WEIGHT   = 2'd1;
  localparam logic [1:0] REG_SIGNAL_WEIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_ERR,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_UPDATE,
    ST_DIFF,
    ST_SIG_SEED,
    ST_LOAD
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SEED,
    OP_ERR,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_UPDATE,
    OP_DIFF,
    OP_SIG_SEED,
    OP_LOAD
  } op_t;

  typedef enum logic [1:0] {
    SEL_FAST,
    SEL_SLOW,
    SEL_SIGNAL
  } sel_t;

  typedef enum logic [1:0] {
    PHASE_EMPTY,
    PHASE_ONE,
    PHASE_SEEDED
  } phase_t;

  typedef struct packed {
    op_t  op;
    sel_t sel;
  } cmd_t;

endpackage

/* src/macd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MACD controller
// Sequences capture, the three EMA updates and the result load, and holds
// the series phase and the output valid flag.
// ----------------------------------------------------------------------------
module macd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          start_of_series,
  output logic          out_valid,
  input  logic          out_ready,
  output macd_pkg::cmd_t cmd
);
  import macd_pkg::*;

  state_t state, state_next;
  sel_t   sel, sel_next;
  phase_t phase, phase_next;
  logic   out_valid_next;
  logic   load_ok;

  assign load_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= SEL_FAST;
      phase     <= PHASE_EMPTY;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    sel_next       = sel;
    phase_next     = phase;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          sel_next = SEL_FAST;
          if (start_of_series || phase == PHASE_EMPTY) begin
            state_next = ST_SEED;
          end else begin
            state_next = ST_ERR;
          end
        end
      end
      ST_SEED: begin
        phase_next = PHASE_ONE;
        state_next = ST_LOAD;
      end
      ST_ERR:    state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_UPDATE;
      ST_UPDATE: begin
        case (sel)
          SEL_FAST: begin
            sel_next   = SEL_SLOW;
            state_next = ST_ERR;
          end
          SEL_SLOW:   state_next = ST_DIFF;
          SEL_SIGNAL: state_next = ST_LOAD;
          default:    state_next = ST_LOAD;
        endcase
      end
      ST_DIFF: begin
        if (phase == PHASE_ONE) begin
          phase_next = PHASE_SEEDED;
          state_next = ST_SIG_SEED;
        end else begin
          sel_next   = SEL_SIGNAL;
          state_next = ST_ERR;
        end
      end
      ST_SIG_SEED: state_next = ST_LOAD;
      ST_LOAD: begin
        if (load_ok) begin
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    cmd.sel  = sel;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_CAPTURE;
        end
      end
      ST_SEED:     cmd.op = OP_SEED;
      ST_ERR:      cmd.op = OP_ERR;
      ST_MUL_LO:   cmd.op = OP_MUL_LO;
      ST_MUL_HI:   cmd.op = OP_MUL_HI;
      ST_UPDATE:   cmd.op = OP_UPDATE;
      ST_DIFF:     cmd.op = OP_DIFF;
      ST_SIG_SEED: cmd.op = OP_SIG_SEED;
      ST_LOAD: begin
        if (load_ok) begin
          cmd.op = OP_LOAD;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

/* src/macd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MACD datapath
// Weight registers, EMA state and one shared multiplier that forms the
// weighted error in a low and a high partial product.
// ----------------------------------------------------------------------------
module macd_datapath #(
  parameter int PRICE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  macd_pkg::cmd_t                       cmd,
  input  logic [PRICE_WIDTH-1:0]               close_price,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [macd_pkg::WEIGHT_WIDTH-1:0]    cfg_data,
  output logic signed [PRICE_WIDTH:0]          difference_line,
  output logic signed [PRICE_WIDTH:0]          signal_line,
  output logic signed [PRICE_WIDTH+1:0]        histogram
);
  import macd_pkg::*;

  localparam int W   = PRICE_WIDTH;
  localparam int SW  = W + 5;                 // sum width, holds any update
  localparam int HW  = W + 2 - FRAC_BITS;     // high part of the error
  localparam int MAW = (HW > FRAC_BITS + 1) ? HW : FRAC_BITS + 1;
  localparam int PRW = MAW + WEIGHT_WIDTH + 1;

  logic [WEIGHT_WIDTH-1:0] fast_weight, slow_weight, signal_weight;
  logic [W-1:0]            price;
  logic [W-1:0]            fast_average, slow_average;
  logic signed [W:0]       signal_average;
  logic signed [W:0]       dif;
  logic signed [W+1:0]     err;
  logic signed [PRW-1:0]   prod;
  logic [WEIGHT_WIDTH-1:0] lo_part;

  logic signed [SW-1:0]    avg_cur, x_cur, lo_bound, hi_bound, pmax_s;
  logic [WEIGHT_WIDTH-1:0] w_cur;
  logic signed [SW-1:0]    err_wide, sum, clamped;
  logic signed [MAW-1:0]   mul_a;
  logic signed [WEIGHT_WIDTH:0] mul_b;
  logic signed [PRW-1:0]   mul_p;

  assign pmax_s = $signed({{(SW-W){1'b0}}, {W{1'b1}}});

  always_comb begin
    avg_cur  = $signed({{(SW-W){1'b0}}, fast_average});
    x_cur    = $signed({{(SW-W){1'b0}}, price});
    w_cur    = fast_weight;
    lo_bound = '0;
    hi_bound = pmax_s;
    case (cmd.sel)
      SEL_FAST: begin
        avg_cur = $signed({{(SW-W){1'b0}}, fast_average});
        w_cur   = fast_weight;
      end
      SEL_SLOW: begin
        avg_cur = $signed({{(SW-W){1'b0}}, slow_average});
        w_cur   = slow_weight;
      end
      SEL_SIGNAL: begin
        avg_cur  = SW'(signal_average);
        x_cur    = SW'(dif);
        w_cur    = signal_weight;
        lo_bound = -pmax_s;
      end
      default: begin
        avg_cur = $signed({{(SW-W){1'b0}}, fast_average});
      end
    endcase
  end

  assign err_wide = x_cur - avg_cur;

  // The error is split at the binary point: the low part is unsigned and
  // its product keeps only the bits above the point, so together the two
  // passes give the floor of weight times error.
  assign mul_a = (cmd.op == OP_MUL_LO) ? MAW'($signed({1'b0, err[FRAC_BITS-1:0]}))
                                       : MAW'($signed(err[W+1:FRAC_BITS]));
  assign mul_b = $signed({1'b0, w_cur});
  assign mul_p = mul_a * mul_b;

  assign sum = avg_cur + SW'(prod) + SW'($signed({1'b0, lo_part}));

  always_comb begin
    if (sum < lo_bound) begin
      clamped = lo_bound;
    end else if (sum > hi_bound) begin
      clamped = hi_bound;
    end else begin
      clamped = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_weight   <= FAST_WEIGHT_RESET;
      slow_weight   <= SLOW_WEIGHT_RESET;
      signal_weight <= SIGNAL_WEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FAST_WEIGHT:   fast_weight   <= cfg_data;
        REG_SLOW_WEIGHT:   slow_weight   <= cfg_data;
        REG_SIGNAL_WEIGHT: signal_weight <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_average   <= '0;
      slow_average   <= '0;
      signal_average <= '0;
    end else begin
      case (cmd.op)
        OP_SEED: begin
          fast_average   <= price;
          slow_average   <= price;
          signal_average <= '0;
        end
        OP_UPDATE: begin
          case (cmd.sel)
            SEL_FAST:   fast_average   <= clamped[W-1:0];
            SEL_SLOW:   slow_average   <= clamped[W-1:0];
            SEL_SIGNAL: signal_average <= clamped[W:0];
            default: begin
            end
          endcase
        end
        OP_SIG_SEED: signal_average <= dif;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: price <= close_price;
      OP_SEED:    dif   <= '0;
      OP_ERR:     err   <= err_wide[W+1:0];
      OP_MUL_LO:  prod  <= mul_p;
      OP_MUL_HI: begin
        lo_part <= prod[FRAC_BITS+WEIGHT_WIDTH-1:FRAC_BITS];
        prod    <= mul_p;
      end
      OP_DIFF: dif <= $signed({1'b0, fast_average}) - $signed({1'b0, slow_average});
      OP_LOAD: begin
        difference_line <= dif;
        signal_line     <= signal_average;
        histogram       <= $signed({dif[W], dif})
                           - $signed({signal_average[W], signal_average});
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/macd_indicator_stream_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MACD indicator stream, top level
// A seeding word is seeded and loaded; the second word of a series runs the
// fast and slow updates and seeds the signal line; any other word runs all
// three EMA updates, which share one multiplier (error, low product, high
// product, add). The next word waits for the load, which an output stall delays.
// Synchronous reset restores the default weights and clears all EMA state.
// ----------------------------------------------------------------------------
module macd_indicator_stream_top #(
  parameter int PRICE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [PRICE_WIDTH-1:0]            close_price,
  input  logic                              start_of_series,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [PRICE_WIDTH:0]       difference_line,
  output logic signed [PRICE_WIDTH:0]       signal_line,
  output logic signed [PRICE_WIDTH+1:0]     histogram,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [macd_pkg::WEIGHT_WIDTH-1:0] cfg_data
);
  import macd_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  macd_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .start_of_series (start_of_series),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cmd             (cmd)
  );

  macd_datapath #(
    .PRICE_WIDTH (PRICE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .close_price     (close_price),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .difference_line (difference_line),
    .signal_line     (signal_line),
    .histogram       (histogram)
  );

  // The block does not accept another word in the cycle after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again right after an accept");

  // A shown result is always internally consistent.
  a_histogram_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (histogram == ($signed({difference_line[PRICE_WIDTH], difference_line})
                                 - $signed({signal_line[PRICE_WIDTH], signal_line}))))
    else $error("histogram does not match difference minus signal");

  // A seeding word with a free output register yields an all-zero result.
  a_seed_zero: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && start_of_series && !out_valid) |-> ##3
      (out_valid && difference_line == '0 && signal_line == '0 && histogram == '0))
    else $error("seeding word did not give a zero result");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MACD indicator stream testbench
// Sends closing prices through the valid/ready input, predicts the difference,
// signal and histogram words from a fixed-point EMA model kept here, and
// compares every output word in order. It covers directed series, weight
// extremes with saturation, random series under several idle patterns, and a
// long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import macd_pkg::*;

  localparam int PRICE_WIDTH = 32;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint PRICE_MAX = 64'sh0000_0000_FFFF_FFFF;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_BARS_PER_PHASE = 150;

  typedef struct {
    longint diff;
    longint sig;
    longint hist;
  } macd_bar_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [PRICE_WIDTH-1:0]        close_price = '0;
  logic                          start_of_series = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [PRICE_WIDTH:0]   difference_line;
  logic signed [PRICE_WIDTH:0]   signal_line;
  logic signed [PRICE_WIDTH+1:0] histogram;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index = REG_FAST_WEIGHT;
  logic [WEIGHT_WIDTH-1:0]       cfg_data = '0;

  // Predicted EMA state and weights.
  longint                  fast_ema = 0;
  longint                  slow_ema = 0;
  longint                  signal_ema = 0;
  phase_t                  bar_phase = PHASE_EMPTY;
  logic [WEIGHT_WIDTH-1:0] fast_weight_q = FAST_WEIGHT_RESET;
  logic [WEIGHT_WIDTH-1:0] slow_weight_q = SLOW_WEIGHT_RESET;
  logic [WEIGHT_WIDTH-1:0] signal_weight_q = SIGNAL_WEIGHT_RESET;

  macd_bar_t expected_bars[$];
  macd_bar_t oldest_bar;
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  macd_indicator_stream_top #(
    .PRICE_WIDTH(PRICE_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .close_price(close_price),
    .start_of_series(start_of_series),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .difference_line(difference_line),
    .signal_line(signal_line),
    .histogram(histogram),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // The full product fits in 64 bits, so an arithmetic shift gives the floor.
  function automatic longint ema_advance(longint avg, longint x, longint w,
                                         longint lo, longint hi);
    longint nxt;
    nxt = avg + ((w * (x - avg)) >>> FRAC_BITS);
    if (nxt < lo) nxt = lo;
    else if (nxt > hi) nxt = hi;
    return nxt;
  endfunction

  function automatic macd_bar_t predict_bar(logic [PRICE_WIDTH-1:0] price, logic start);
    macd_bar_t r;
    longint p;
    p = {32'd0, price};
    if (start || bar_phase == PHASE_EMPTY) begin
      fast_ema = p;
      slow_ema = p;
      signal_ema = 0;
      bar_phase = PHASE_ONE;
      r = '{0, 0, 0};
    end else begin
      fast_ema = ema_advance(fast_ema, p, {47'd0, fast_weight_q}, 0, PRICE_MAX);
      slow_ema = ema_advance(slow_ema, p, {47'd0, slow_weight_q}, 0, PRICE_MAX);
      r.diff = fast_ema - slow_ema;
      if (bar_phase == PHASE_ONE) begin
        signal_ema = r.diff;
        bar_phase = PHASE_SEEDED;
      end else begin
        signal_ema = ema_advance(signal_ema, r.diff, {47'd0, signal_weight_q},
                                 -PRICE_MAX, PRICE_MAX);
      end
      r.sig = signal_ema;
      r.hist = r.diff - signal_ema;
    end
    return r;
  endfunction

  task automatic send_bar(input logic [PRICE_WIDTH-1:0] price, input logic start);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    close_price = price;
    start_of_series = start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_bars.insert(expected_bars.size(), predict_bar(price, start));
  endtask

  task automatic write_weight(input logic [1:0] index, input logic [WEIGHT_WIDTH-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_FAST_WEIGHT:   fast_weight_q = value;
      REG_SLOW_WEIGHT:   slow_weight_q = value;
      REG_SIGNAL_WEIGHT: signal_weight_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Output side: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_bars.size() == 0) begin
        error_count++;
        $display("%0t: unexpected output word: diff %0d signal %0d hist %0d", $time,
                 difference_line, signal_line, histogram);
      end else begin
        oldest_bar = expected_bars.pop_front();
        check_field("difference_line", oldest_bar.diff, longint'(difference_line));
        check_field("signal_line", oldest_bar.sig, longint'(signal_line));
        check_field("histogram", oldest_bar.hist, longint'(histogram));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed_series();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // The very first word seeds the averages even without the start flag.
    send_bar(32'h0001_0000, 1'b0);
    send_bar(32'h0002_8000, 1'b0);
    send_bar(32'hFFFF_FFFF, 1'b0);
    send_bar(32'h0000_0000, 1'b0);
    send_bar(32'h8000_0000, 1'b0);
    // A restart in mid-series, then a second restart right after it.
    send_bar(32'h1234_5678, 1'b1);
    send_bar(32'h0000_0000, 1'b1);
    send_bar(32'hFFFF_FFFF, 1'b0);
    wait_for_results();
  endtask

  task automatic test_weight_extremes();
    logic [WEIGHT_WIDTH-1:0] extremes [3];
    int k;
    extremes[0] = '0;
    extremes[1] = 17'd65536;
    extremes[2] = '1;
    // Weights above one overshoot, so the averages must saturate.
    for (k = 0; k < 3; k++) begin
      write_weight(REG_FAST_WEIGHT, extremes[k]);
      write_weight(REG_SLOW_WEIGHT, extremes[(k + 1) % 3]);
      write_weight(REG_SIGNAL_WEIGHT, extremes[(k + 2) % 3]);
      send_bar(32'hFFFF_FFFF, 1'b1);
      send_bar(32'h0000_0000, 1'b0);
      send_bar(32'hFFFF_FFFF, 1'b0);
      send_bar(32'h0000_0000, 1'b0);
      send_bar(32'hFFFF_FFFF, 1'b0);
      wait_for_results();
    end
    // A write to the unused index must leave all weights alone.
    write_weight(REG_UNUSED, '1);
    send_bar(32'h0000_0000, 1'b0);
    send_bar(32'h7FFF_FFFF, 1'b0);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int idle_table [4];
    int stall_table [4];
    logic [1:0] weight_regs [3];
    logic [WEIGHT_WIDTH-1:0] w;
    logic [PRICE_WIDTH-1:0] price;
    logic start;
    longint walk;
    int ph, r, i, series_left;
    idle_table = '{0, 56, 0, 21};
    stall_table = '{0, 0, 56, 21};
    weight_regs = '{REG_FAST_WEIGHT, REG_SLOW_WEIGHT, REG_SIGNAL_WEIGHT};
    price = 32'h0064_0000;
    series_left = 0;
    for (ph = 0; ph < 4; ph++) begin
      wait_for_results();
      for (r = 0; r < 3; r++) begin
        case ($urandom_range(9))
          0:       w = '0;
          1:       w = 17'd65536;
          2:       w = WEIGHT_WIDTH'($urandom_range(131071, 65537));
          default: w = WEIGHT_WIDTH'($urandom_range(65535, 1));
        endcase
        write_weight(weight_regs[r], w);
      end
      if ($urandom_range(1)) write_weight(REG_UNUSED, WEIGHT_WIDTH'($urandom));
      send_idle_pct = idle_table[ph];
      recv_stall_pct = stall_table[ph];
      for (i = 0; i < RANDOM_BARS_PER_PHASE; i++) begin
        start = 1'b0;
        if (series_left == 0) begin
          start = 1'b1;
          series_left = $urandom_range(40, 2);
        end
        series_left--;
        if ($urandom_range(99) < 3) start = 1'b1;
        // Mostly a random walk, with some full-range noise and extremes.
        case ($urandom_range(9))
          0: price = $urandom;
          1: price = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
          default: begin
            walk = {32'd0, price} + longint'($urandom_range(1048576)) - 64'sd524288;
            if (walk < 0) walk = 0;
            else if (walk > PRICE_MAX) walk = PRICE_MAX;
            price = walk[PRICE_WIDTH-1:0];
          end
        endcase
        send_bar(price, start);
      end
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_left = HOLD_OFF_CYCLES;
    // Keep offering words while the output is held so that the input stalls.
    for (i = 0; i < 30; i++) send_bar($urandom, i == 0);
    wait_for_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_series();
    test_weight_extremes();
    test_random_traffic();
    test_backpressure();
    wait_for_results();
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
